// File: rtl/core/rgbh_pkg.sv
// Package for the RGB histogram block: command codes, sequencer states and
// fixed field widths. No dependencies.
`default_nettype none
package rgbh_pkg;

  localparam int HEIGHT_W  = 12;
  localparam int CHANNELS  = 3;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_RESET = 12'd256;
  localparam logic REG_MAX_HEIGHT = 1'b0;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PIX_RD,
    S_PIX_WR,
    S_RD_RD,
    S_RD_MUL,
    S_RD_DIV,
    S_RD_OUT
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/rgbh_div.sv
// Iterative restoring divider producing a 12-bit quotient, one bit a cycle.
// Depends on rgbh_pkg.
`default_nettype none
module rgbh_div #(
  parameter int CW = 20
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [CW+rgbh_pkg::HEIGHT_W-1:0]      dividend,
  input  wire logic [CW-1:0]                         divisor,
  output logic                                       done,
  output logic [rgbh_pkg::HEIGHT_W-1:0]              quotient
);

  localparam int DW = CW + rgbh_pkg::HEIGHT_W;
  localparam int SW = $clog2(rgbh_pkg::HEIGHT_W);

  logic          busy;
  logic [SW-1:0] step;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsh;
  logic          ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + SW'(1);
        if (step == SW'(rgbh_pkg::HEIGHT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= DW'(divisor) << (rgbh_pkg::HEIGHT_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh      <= dsh >> 1;
      quotient <= {quotient[rgbh_pkg::HEIGHT_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rgb_histogram_with_scaling.sv
// Top level of the RGB histogram: bin memory, sequencer, peak tracking,
// scaling and the APB register. Depends on rgbh_pkg and rgbh_div.
//
// Channel  Kind          Beat contents
// s_*      stream in     command, red, green, blue, bin_index
// m_*      stream out    red_height, green_height, blue_height, peak_height
// p*       APB register  max_height at byte address 0
//
// One item is in work at a time; all bins lie in one memory of 3*BINS words.
// A pixel reads and writes back the bin of each channel in range and skips a
// channel out of range.
// A read fetches the bin of each channel and, when scaling, divides its count
// with the 12-step divider; otherwise the count passes on unscaled.
// A clear zeroes all 3*BINS words; after reset the same sweep of 3*BINS words
// zeroes the memory, during which no beat is accepted.
// A finished result waits in the output register while the next beat is taken.
`default_nettype none
module rgb_histogram_with_scaling #(
  parameter int                BINS      = 256,
  parameter longint unsigned   MAX_COUNT = 1048575
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [1:0] command, [9:2] red, [17:10] green, [25:18] blue, [33:26] bin_index
  input  wire logic [rgbh_pkg::S_TDATA_W-1:0]      s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [11:0] red_height, [23:12] green_height, [35:24] blue_height,
  // [47:36] peak_height
  output logic [rgbh_pkg::M_TDATA_W-1:0]           m_tdata,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  localparam int HW    = rgbh_pkg::HEIGHT_W;
  localparam int CW    = $clog2(MAX_COUNT + 1);
  localparam int DW    = CW + HW;
  localparam int PW    = (CW > HW) ? CW : HW;
  localparam int DEPTH = rgbh_pkg::CHANNELS * BINS;
  localparam int AW    = $clog2(DEPTH);

  rgbh_pkg::state_t state, state_next;

  logic [HW-1:0] max_height;
  logic [CW-1:0] peak;
  logic [1:0]    ch;
  logic [AW-1:0] clr_addr;

  logic [1:0]    cmd_q;
  logic [7:0]    red_q, green_q, blue_q, bin_q;
  logic [HW-1:0] heights [rgbh_pkg::CHANNELS];

  logic [CW-1:0] mem [DEPTH];
  logic [CW-1:0] mem_rdata;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [CW-1:0] mem_wdata;

  logic [7:0]    pix_val, sel_val;
  logic          in_range, ch_last, scale, out_free, rd_phase;
  logic [AW-1:0] chan_addr;
  logic [CW-1:0] incremented, count_in;
  logic [DW-1:0] product;
  logic [HW-1:0] peak_h;
  logic          div_start, div_done;
  logic [HW-1:0] quotient;
  logic          cfg_write;

  always_comb begin
    case (ch)
      2'd0:    pix_val = red_q;
      2'd1:    pix_val = green_q;
      default: pix_val = blue_q;
    endcase
  end

  assign rd_phase    = (state == rgbh_pkg::S_RD_RD) || (state == rgbh_pkg::S_RD_MUL)
                       || (state == rgbh_pkg::S_RD_DIV);
  assign sel_val     = rd_phase ? bin_q : pix_val;
  assign in_range    = 32'(sel_val) < 32'(BINS);
  assign chan_addr   = AW'(32'(ch) * 32'(BINS) + 32'(sel_val));
  assign ch_last     = (ch == 2'(rgbh_pkg::CHANNELS - 1));
  assign incremented = (mem_rdata < CW'(MAX_COUNT)) ? mem_rdata + CW'(1) : mem_rdata;
  assign count_in    = in_range ? mem_rdata : '0;
  assign product     = DW'(count_in) * DW'(max_height);
  assign scale       = PW'(peak) > PW'(max_height);
  assign peak_h      = scale ? max_height : HW'(peak);
  assign out_free    = !m_tvalid || m_tready;

  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == rgbh_pkg::REG_MAX_HEIGHT) ? 32'(max_height) : '0;

  always_comb begin
    state_next = state;
    case (state)
      rgbh_pkg::S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = rgbh_pkg::S_IDLE;
      end
      rgbh_pkg::S_IDLE: begin
        if (s_tvalid) begin
          case (s_tdata[1:0])
            rgbh_pkg::CMD_PIXEL: state_next = rgbh_pkg::S_PIX_RD;
            rgbh_pkg::CMD_READ:  state_next = rgbh_pkg::S_RD_RD;
            rgbh_pkg::CMD_CLEAR: state_next = rgbh_pkg::S_CLEAR;
            default:             state_next = rgbh_pkg::S_IDLE;
          endcase
        end
      end
      rgbh_pkg::S_PIX_RD: begin
        if (in_range)     state_next = rgbh_pkg::S_PIX_WR;
        else if (ch_last) state_next = rgbh_pkg::S_IDLE;
      end
      rgbh_pkg::S_PIX_WR: begin
        state_next = ch_last ? rgbh_pkg::S_IDLE : rgbh_pkg::S_PIX_RD;
      end
      rgbh_pkg::S_RD_RD: state_next = rgbh_pkg::S_RD_MUL;
      rgbh_pkg::S_RD_MUL: begin
        if (scale)        state_next = rgbh_pkg::S_RD_DIV;
        else if (ch_last) state_next = rgbh_pkg::S_RD_OUT;
        else              state_next = rgbh_pkg::S_RD_RD;
      end
      rgbh_pkg::S_RD_DIV: begin
        if (div_done) state_next = ch_last ? rgbh_pkg::S_RD_OUT : rgbh_pkg::S_RD_RD;
      end
      rgbh_pkg::S_RD_OUT: begin
        if (out_free) state_next = rgbh_pkg::S_IDLE;
      end
      default: state_next = rgbh_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    s_tready  = (state == rgbh_pkg::S_IDLE);
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = chan_addr;
    mem_wdata = incremented;
    div_start = 1'b0;
    case (state)
      rgbh_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      rgbh_pkg::S_PIX_RD: mem_re = in_range;
      rgbh_pkg::S_PIX_WR: mem_we = 1'b1;
      rgbh_pkg::S_RD_RD:  mem_re = in_range;
      rgbh_pkg::S_RD_MUL: div_start = scale;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_addr];
    end
  end

  rgbh_div #(
    .CW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (peak),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rgbh_pkg::S_CLEAR;
      clr_addr   <= '0;
      peak       <= '0;
      ch         <= '0;
      max_height <= rgbh_pkg::MAX_HEIGHT_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write && paddr[2] == rgbh_pkg::REG_MAX_HEIGHT) begin
        max_height <= pwdata[HW-1:0];
      end
      if (state == rgbh_pkg::S_RD_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        rgbh_pkg::S_CLEAR: begin
          peak     <= '0;
          clr_addr <= (clr_addr == AW'(DEPTH - 1)) ? '0 : clr_addr + AW'(1);
        end
        rgbh_pkg::S_IDLE: begin
          ch <= '0;
        end
        rgbh_pkg::S_PIX_RD: begin
          if (!in_range) ch <= ch + 2'd1;
        end
        rgbh_pkg::S_PIX_WR: begin
          if (incremented > peak) peak <= incremented;
          ch <= ch + 2'd1;
        end
        rgbh_pkg::S_RD_MUL: begin
          if (!scale) ch <= ch + 2'd1;
        end
        rgbh_pkg::S_RD_DIV: begin
          if (div_done) ch <= ch + 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == rgbh_pkg::S_IDLE && s_tvalid) begin
      cmd_q   <= s_tdata[1:0];
      red_q   <= s_tdata[9:2];
      green_q <= s_tdata[17:10];
      blue_q  <= s_tdata[25:18];
      bin_q   <= s_tdata[33:26];
    end
    if (state == rgbh_pkg::S_RD_MUL && !scale) begin
      heights[ch] <= HW'(count_in);
    end
    if (state == rgbh_pkg::S_RD_DIV && div_done) begin
      heights[ch] <= quotient;
    end
    if (state == rgbh_pkg::S_RD_OUT && out_free) begin
      m_tdata <= {peak_h, heights[2], heights[1], heights[0]};
    end
  end

`ifndef SYNTHESIS
  a_mem_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == rgbh_pkg::S_CLEAR || state == rgbh_pkg::S_PIX_WR))
    else $error("bin memory written outside clear or pixel update");

  a_peak_covers_write: assert property (@(posedge clk) disable iff (rst)
    (state == rgbh_pkg::S_PIX_WR) |=> (peak >= $past(mem_wdata)))
    else $error("peak below an updated bin count");

  a_heights_bounded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:0] <= m_tdata[47:36] && m_tdata[23:12] <= m_tdata[47:36]
                  && m_tdata[35:24] <= m_tdata[47:36]))
    else $error("bar height above peak height");

  a_div_done_phase: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == rgbh_pkg::S_RD_DIV && cmd_q == rgbh_pkg::CMD_READ))
    else $error("divider finished outside a read");
`endif

endmodule
`default_nettype wire

// File: tb/rgb_histogram_with_scaling_tb.sv
// Testbench for rgb_histogram_with_scaling: drives pixel, read and clear beats
// and APB writes of max_height, and checks every read result against a
// histogram scoreboard. Depends on rgbh_pkg and the block itself.
`default_nettype none
module rgb_histogram_with_scaling_tb;

  localparam int HEIGHT_W = rgbh_pkg::HEIGHT_W;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 800;
  localparam int SQUEEZE_CYCLES = 300;

  typedef struct {
    bit [HEIGHT_W-1:0] red;
    bit [HEIGHT_W-1:0] green;
    bit [HEIGHT_W-1:0] blue;
    bit [HEIGHT_W-1:0] peak;
  } heights_t;

  class hist_scoreboard;
    bit [19:0] tally[rgbh_pkg::CHANNELS][256];
    bit [19:0] peak;
    bit [HEIGHT_W-1:0] max_height;
    heights_t heights_q[$];
    int errors;

    function new();
      wipe();
      max_height = rgbh_pkg::MAX_HEIGHT_RESET;
      errors = 0;
    endfunction

    function void wipe();
      foreach (tally[c, v]) tally[c][v] = '0;
      peak = '0;
    endfunction

    function void set_max_height(bit [HEIGHT_W-1:0] value);
      max_height = value;
    endfunction

    function void bump(int channel, bit [7:0] level);
      if (tally[channel][level] < 20'hFFFFF) tally[channel][level]++;
      if (tally[channel][level] > peak) peak = tally[channel][level];
    endfunction

    function bit [HEIGHT_W-1:0] bar_height(bit [19:0] count);
      longint unsigned product;
      if (peak > max_height) begin
        product = longint'(count) * longint'(max_height);
        return HEIGHT_W'(product / longint'(peak));
      end
      return count[HEIGHT_W-1:0];
    endfunction

    function void note_beat(logic [rgbh_pkg::S_TDATA_W-1:0] beat);
      heights_t want;
      bit [7:0] bin;
      bin = beat[33:26];
      case (beat[1:0])
        rgbh_pkg::CMD_PIXEL: begin
          bump(0, beat[9:2]);
          bump(1, beat[17:10]);
          bump(2, beat[25:18]);
        end
        rgbh_pkg::CMD_CLEAR: begin
          wipe();
        end
        rgbh_pkg::CMD_READ: begin
          want.red   = bar_height(tally[0][bin]);
          want.green = bar_height(tally[1][bin]);
          want.blue  = bar_height(tally[2][bin]);
          want.peak  = (peak > max_height) ? max_height : peak[HEIGHT_W-1:0];
          heights_q.push_back(want);
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string name, bit [HEIGHT_W-1:0] want,
                                logic [HEIGHT_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_heights(logic [rgbh_pkg::M_TDATA_W-1:0] beat);
      heights_t want;
      if (heights_q.size() == 0) begin
        $error("result beat with no read pending: %h", beat);
        errors++;
        return;
      end
      want = heights_q.pop_front();
      compare_field("red_height", want.red, beat[11:0]);
      compare_field("green_height", want.green, beat[23:12]);
      compare_field("blue_height", want.blue, beat[35:24]);
      compare_field("peak_height", want.peak, beat[47:36]);
    endfunction

    function int pending();
      return heights_q.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [rgbh_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [rgbh_pkg::M_TDATA_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  hist_scoreboard board = new();
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 1'b0;

  rgb_histogram_with_scaling i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [rgbh_pkg::S_TDATA_W-1:0] pack_beat(logic [1:0] cmd,
                                                               logic [7:0] r,
                                                               logic [7:0] g,
                                                               logic [7:0] b,
                                                               logic [7:0] bin);
    return {6'b0, bin, b, g, r, cmd};
  endfunction

  // Levels cluster on a few bins so that peaks grow past small bar heights.
  function automatic logic [7:0] pick_level();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return 8'($urandom_range(3));
    if (roll < 50) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [rgbh_pkg::S_TDATA_W-1:0] random_beat();
    int roll;
    logic [1:0] cmd;
    roll = $urandom_range(99);
    if (roll < 2) cmd = rgbh_pkg::CMD_CLEAR;
    else if (roll < 6) cmd = CMD_UNUSED;
    else if (roll < 36) cmd = rgbh_pkg::CMD_READ;
    else cmd = rgbh_pkg::CMD_PIXEL;
    return pack_beat(cmd, pick_level(), pick_level(), pick_level(), pick_level());
  endfunction

  task automatic send_beat(input logic [rgbh_pkg::S_TDATA_W-1:0] beat);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_beat(beat);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // A clear returns nothing, so the block may still be sweeping once the
  // last read has come back; the settle covers the longest clear.
  task automatic write_max_height(input logic [HEIGHT_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(rgbh_pkg::REG_MAX_HEIGHT) << 2;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_max_height(value);
  endtask

  task automatic run_phase(input logic [HEIGHT_W-1:0] height, input int src_pct,
                           input int sink_pct, input int count, input bit squeeze);
    write_max_height(height);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 4) wait_drained();
      if (squeeze && i == count / 2) begin
        hold_req = 1'b1;
        for (int k = 0; k < 6; k++)
          send_beat(pack_beat(rgbh_pkg::CMD_READ, 8'($urandom), 8'($urandom),
                              8'($urandom), pick_level()));
      end
      send_beat(random_beat());
    end
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) board.check_heights(m_tdata);
      if (hold_req && hold_left == 0) begin
        hold_left = SQUEEZE_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Empty bins, extremes of every channel, the unused command and a clear.
    send_beat(pack_beat(rgbh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(pack_beat(rgbh_pkg::CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_beat(pack_beat(rgbh_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_beat(pack_beat(rgbh_pkg::CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_beat(pack_beat(rgbh_pkg::CMD_PIXEL, 8'h00, 8'hFF, 8'h80, 8'h55));
    send_beat(pack_beat(rgbh_pkg::CMD_PIXEL, 8'hFF, 8'h00, 8'h01, 8'hAA));
    send_beat(pack_beat(rgbh_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(pack_beat(rgbh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(pack_beat(rgbh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_beat(pack_beat(rgbh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 8'h80));
    send_beat(pack_beat(rgbh_pkg::CMD_READ, 8'hAA, 8'h55, 8'hFF, 8'h01));
    send_beat(pack_beat(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_beat(pack_beat(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(pack_beat(rgbh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(pack_beat(rgbh_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(pack_beat(rgbh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(pack_beat(rgbh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_beat(pack_beat(rgbh_pkg::CMD_PIXEL, 8'h07, 8'h07, 8'h07, 8'h00));
    send_beat(pack_beat(rgbh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 8'h07));

    run_phase(12'd1, 0, 0, 225, 1'b1);
    run_phase(12'd4095, 62, 0, 225, 1'b0);
    run_phase(12'd9, 0, 62, 225, 1'b0);
    run_phase(12'd0, 33, 33, 225, 1'b0);
    run_phase(12'd60, 0, 0, 225, 1'b0);
    run_phase(12'd2, 33, 33, 225, 1'b1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
rtl/core/rgbh_pkg.sv
rtl/core/rgbh_div.sv
rtl/core/rgb_histogram_with_scaling.sv
tb/rgb_histogram_with_scaling_tb.sv
